[design/sorted_list_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list table unit
// Clocked property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_UNIT_ASSERT_SVH
`define SORTED_LIST_TABLE_UNIT_ASSERT_SVH

// Check a property on every rising edge outside of reset
`define SLT_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define SLT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and cell interface types of the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int POS_W    = 4;
    localparam int REQ_W    = 2;

    typedef logic signed [WORD_W-1:0] word_t;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_BADPOS  = 2'd3
    } status_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic  ins;
        logic  rem;
        word_t value;
    } cmd_t;

    // Compare flags a cell hands to its right neighbor
    typedef struct packed {
        logic gt;
        logic ge;
        logic hit;
    } flags_t;

endpackage

[design/slt_cell.sv]
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted list: holds an entry, compares it against the
// broadcast value and shifts right on insert or left on remove.
// ----------------------------------------------------------------------------
module slt_cell (
    input  logic           clk,
    input  slt_pkg::cmd_t  cmd,
    input  slt_pkg::word_t key,
    input  logic           occupied,
    input  logic           tail,
    input  slt_pkg::flags_t left_flags,
    input  slt_pkg::word_t left_entry,
    input  slt_pkg::word_t right_entry,
    output slt_pkg::flags_t flags,
    output slt_pkg::word_t entry
);
    import slt_pkg::*;

    word_t entry_reg;
    word_t entry_next;

    // Compare the held entry against the request value, straight from the port
    always_comb
    begin
        flags.gt  = occupied && (entry_reg > key);
        flags.ge  = occupied && (entry_reg >= key);
        flags.hit = occupied && (entry_reg == key) && !left_flags.ge;
    end

    // Shift right past the insert slot, drop the removed entry by shifting left
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (left_flags.gt)
                entry_next = left_entry;
            else if (flags.gt || tail)
                entry_next = cmd.value;
        end
        else if (cmd.rem)
        begin
            if (flags.ge)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[design/sorted_list_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Sorted list of signed words with insert, remove and positional read.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with req_type, value and position;
// results leave on res_valid/res_ready with status, read_value, count,
// empty_res and full_res. Every request yields exactly one result.
// The list lives in a row of cells, one entry each. A request is broadcast
// to all cells, each compares its entry with the value and shifts toward
// its neighbor in the same cycle as the request transfer.
// The result is registered: res_valid rises in the cycle after the transfer,
// and a new request is taken every cycle while results are taken, 1 item per cycle sustained.
// When the receiver stalls, the result register holds and req_ready drops
// until the waiting result is transferred; req_ready also stays high in the
// cycle that the waiting result leaves.
// Reset empties the list (count zero) and clears res_valid; entry storage
// itself is not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [slt_pkg::REQ_W-1:0]    req_type,
    input  logic signed [slt_pkg::WORD_W-1:0] value,
    input  logic [slt_pkg::POS_W-1:0]    position,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [1:0]                   status,
    output logic signed [slt_pkg::WORD_W-1:0] read_value,
    output logic [slt_pkg::COUNT_W-1:0]  count,
    output logic                         empty_res,
    output logic                         full_res
);
    import slt_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    status_t            status_reg;
    status_t            status_next;
    word_t              read_value_reg;
    word_t              read_value_next;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic               empty_reg;
    logic               full_reg;

    logic    accept;
    logic    is_full;
    logic    found;
    logic    pos_ok;
    word_t   rd_word;
    req_t    req;
    cmd_t    cmd;
    flags_t  cell_flags [CAPACITY];
    word_t   cell_entry [CAPACITY];
    logic [CAPACITY-1:0] hits;

    assign req       = req_t'(req_type);
    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));

    // Gather first-match flags from the row
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            hits[i] = cell_flags[i].hit;
    end
    assign found = |hits;

    // Broadcast the command; remove only takes effect on a match
    always_comb
    begin
        cmd.value = value;
        cmd.ins   = accept && (req == REQ_INSERT) && !is_full;
        cmd.rem   = accept && (req == REQ_REMOVE) && found;
    end

    // Row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        flags_t left_f;
        word_t  left_e;
        word_t  right_e;

        if (gi == 0)
        begin : g_first
            assign left_f = '0;
            assign left_e = '0;
        end
        else
        begin : g_mid
            assign left_f = cell_flags[gi-1];
            assign left_e = cell_entry[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_body
            assign right_e = cell_entry[gi+1];
        end

        slt_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .key         (value),
            .occupied    (CNT_W'(gi) < count_reg),
            .tail        (CNT_W'(gi) == count_reg),
            .left_flags  (left_f),
            .left_entry  (left_e),
            .right_entry (right_e),
            .flags       (cell_flags[gi]),
            .entry       (cell_entry[gi])
        );
    end

    // Positional read
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (32'(position) == 32'(i))
                rd_word = cell_entry[i];
        end
    end
    assign pos_ok = (32'(position) < 32'(count_reg));

    // Work out the result and the new count
    always_comb
    begin
        count_next      = count_reg;
        read_value_next = '0;
        status_next     = ST_BADPOS;
        if (cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.rem)
            count_next = count_reg - CNT_W'(1);
        unique case (req)
            REQ_INSERT: status_next = is_full ? ST_FULL : ST_OK;
            REQ_REMOVE: status_next = found ? ST_OK : ST_MISSING;
            REQ_READ:
            begin
                if (pos_ok)
                begin
                    status_next     = ST_OK;
                    read_value_next = rd_word;
                end
            end
            default:    status_next = ST_BADPOS;
        endcase
    end

    // Hold the result until transferred
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            cnt_out_reg    <= COUNT_W'(count_next);
            empty_reg      <= (count_next == '0);
            full_reg       <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = cnt_out_reg;
    assign empty_res  = empty_reg;
    assign full_res   = full_reg;

    // Checks
`include "sorted_list_table_unit_assert.svh"

    `SLT_ASSERT_ALWAYS(a_count_range,
        count_reg <= CNT_W'(CAPACITY),
        "entry count beyond capacity")
    `SLT_ASSERT_CLK(a_insert_grows,
        cmd.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)),
        "insert did not grow the list")
    `SLT_ASSERT_CLK(a_remove_needs_entries,
        cmd.rem |-> (count_reg != '0),
        "remove matched on an empty list")
    `SLT_ASSERT_CLK(a_nonok_zero_data,
        (res_valid && (status != ST_OK)) |-> (read_value == '0),
        "failed result carries data")
    `SLT_ASSERT_CLK(a_empty_flag,
        res_valid |-> (empty_res == (count == '0)),
        "empty flag disagrees with count")

endmodule

[test/tb_sorted_list_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_sorted_list_table_unit
// Self-checking bench for the sorted list table: insert, remove and read.
// ----------------------------------------------------------------------------
// A shadow copy of the sorted list is updated at every request transfer and
// produces the status, read word, count and flags expected for it. Results are
// matched in order against those predictions. Directed requests cover the
// empty and full list, word extremes, duplicates, absent values, bad positions
// and the unused request code. Random traffic then runs under three idle
// patterns, with a long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_sorted_list_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int LONG_HOLD = 80;

    // Expected contents of one result transfer
    typedef struct {
        status_t           st;
        word_t             rd;
        logic [COUNT_W-1:0] cnt;
        logic              empty;
        logic              full;
    } list_result_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [REQ_W-1:0]   req_type;
    word_t              value;
    logic [POS_W-1:0]   position;
    logic               res_valid;
    logic               res_ready;
    logic [1:0]         status;
    word_t              read_value;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               full_res;

    // Shadow list, predictions in flight, and bench knobs
    word_t        shadow_list [CAPACITY];
    int           shadow_len;
    list_result_t pending_results [$];
    list_result_t head_result;
    int           mismatch_count;
    int           src_idle_pct;
    int           sink_stall_pct;
    int           sink_hold_left;

    sorted_list_table_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .status     (status),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res),
        .full_res   (full_res)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one request to the shadow list and return the expected result
    function automatic list_result_t apply_list_request(input req_t kind, input word_t val,
                                                        input logic [POS_W-1:0] pos);
        list_result_t r;
        int           slot;
        r.st = ST_BADPOS;
        r.rd = '0;
        case (kind)
            REQ_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    // place after every entry equal to the value
                    slot = 0;
                    while (slot < shadow_len && shadow_list[slot] <= val)
                        slot++;
                    for (int k = shadow_len; k > slot; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[slot] = val;
                    shadow_len++;
                    r.st = ST_OK;
                end
            end
            REQ_REMOVE:
            begin
                slot = 0;
                while (slot < shadow_len && shadow_list[slot] != val)
                    slot++;
                if (slot >= shadow_len)
                    r.st = ST_MISSING;
                else
                begin
                    for (int k = slot + 1; k < shadow_len; k++)
                        shadow_list[k-1] = shadow_list[k];
                    shadow_len--;
                    r.st = ST_OK;
                end
            end
            REQ_READ:
            begin
                if (int'(pos) < shadow_len)
                begin
                    r.st = ST_OK;
                    r.rd = shadow_list[pos];
                end
            end
            default: r.st = ST_BADPOS;
        endcase
        r.cnt   = COUNT_W'(shadow_len);
        r.empty = (shadow_len == 0);
        r.full  = (shadow_len == CAPACITY);
        return r;
    endfunction

    // Random word: often a narrow band for duplicates, some extremes, else any word
    function automatic word_t pick_word();
        case ($urandom_range(9))
            0, 1, 2, 3: return word_t'(int'($urandom_range(16)) - 8);
            4:
            begin
                case ($urandom_range(5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh8000_0001;
                    2: return 32'sh7FFF_FFFF;
                    3: return 32'sh7FFF_FFFE;
                    4: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return word_t'($urandom);
        endcase
    endfunction

    // Drive one request, hold it until transfer, then record the prediction
    task automatic send_req(input req_t kind, input word_t val, input logic [POS_W-1:0] pos);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        value     <= val;
        position  <= pos;
        do
            @(posedge clk);
        while (!req_ready);
        pending_results.push_back(apply_list_request(kind, val, pos));
    endtask

    // Drop the request side, then wait until every predicted result has been transferred
    task automatic wait_results_done();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_req(REQ_READ, 32'sd0, 4'd0);
        send_req(REQ_REMOVE, 32'sd0, 4'd0);
        send_req(REQ_NONE, 32'sd0, 4'd0);
        send_req(REQ_INSERT, 32'sh7FFF_FFFF, 4'd0);
        send_req(REQ_INSERT, 32'sh8000_0000, 4'd0);
        send_req(REQ_INSERT, 32'sd0, 4'd0);
        send_req(REQ_INSERT, -32'sd1, 4'd0);
        send_req(REQ_INSERT, 32'sd0, 4'd0);
        send_req(REQ_INSERT, 32'sd0, 4'd0);
        send_req(REQ_READ, 32'sd0, 4'd0);
        send_req(REQ_READ, 32'sd0, 4'd5);
        send_req(REQ_READ, 32'sd0, 4'd6);
        send_req(REQ_READ, 32'sd0, 4'd15);
        send_req(REQ_REMOVE, 32'sd0, 4'd0);
        send_req(REQ_REMOVE, 32'sd5, 4'd0);
        send_req(REQ_REMOVE, 32'sh7FFF_FFFF, 4'd0);
        send_req(REQ_REMOVE, 32'sh8000_0000, 4'd0);
        send_req(REQ_NONE, -32'sd1, 4'd15);
        send_req(REQ_READ, 32'sd0, 4'd1);
        wait_results_done();
    endtask

    // Fill to capacity, push past it, then drain to empty
    task automatic test_fill_and_drain();
        while (shadow_len < CAPACITY)
            send_req(REQ_INSERT, pick_word(), POS_W'($urandom_range(15)));
        send_req(REQ_INSERT, pick_word(), 4'd0);
        send_req(REQ_INSERT, 32'sh7FFF_FFFF, 4'd15);
        send_req(REQ_READ, 32'sd0, 4'd15);
        send_req(REQ_NONE, word_t'($urandom), 4'd15);
        while (shadow_len > 0)
            send_req(REQ_REMOVE, shadow_list[$urandom_range(shadow_len - 1)],
                     POS_W'($urandom_range(15)));
        send_req(REQ_REMOVE, pick_word(), 4'd0);
        send_req(REQ_READ, 32'sd0, 4'd0);
        wait_results_done();
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_result_backpressure();
        src_idle_pct   = 0;
        sink_hold_left = LONG_HOLD;
        for (int i = 0; i < 24; i++)
            send_req(req_t'($urandom_range(2)), pick_word(), POS_W'($urandom_range(15)));
        wait_results_done();
    endtask

    // Random requests in bursts that grow, shrink or hold the list size
    task automatic test_random_traffic(input int n_items);
        int    ins_w;
        int    rem_w;
        int    r;
        word_t val;
        ins_w = 35;
        rem_w = 30;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       begin ins_w = 55; rem_w = 15; end
                    1:       begin ins_w = 15; rem_w = 50; end
                    default: begin ins_w = 35; rem_w = 30; end
                endcase
            end
            r = $urandom_range(99);
            if (r < 4)
                send_req(REQ_NONE, word_t'($urandom), POS_W'($urandom_range(15)));
            else if (r < 4 + ins_w)
                send_req(REQ_INSERT, pick_word(), POS_W'($urandom_range(15)));
            else if (r < 4 + ins_w + rem_w)
            begin
                if (shadow_len > 0 && $urandom_range(99) < 75)
                    val = shadow_list[$urandom_range(shadow_len - 1)];
                else
                    val = pick_word();
                send_req(REQ_REMOVE, val, POS_W'($urandom_range(15)));
            end
            else if (shadow_len > 0 && $urandom_range(99) < 80)
                send_req(REQ_READ, word_t'($urandom), POS_W'($urandom_range(shadow_len - 1)));
            else
                send_req(REQ_READ, word_t'($urandom), POS_W'($urandom_range(15)));
        end
        wait_results_done();
    endtask

    // Result side: random stalls plus the long hold-off
    always @(posedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            sink_hold_left <= sink_hold_left - 1;
            res_ready      <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d read_value=%0d count=%0d",
                         $time, status, read_value, count);
                mismatch_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (status !== head_result.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_result.st, status);
                    mismatch_count++;
                end
                if (read_value !== head_result.rd)
                begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, head_result.rd, read_value);
                    mismatch_count++;
                end
                if (count !== head_result.cnt)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, head_result.cnt, count);
                    mismatch_count++;
                end
                if (empty_res !== head_result.empty)
                begin
                    $display("%0t: empty_res expected %0b actual %0b",
                             $time, head_result.empty, empty_res);
                    mismatch_count++;
                end
                if (full_res !== head_result.full)
                begin
                    $display("%0t: full_res expected %0b actual %0b",
                             $time, head_result.full, full_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Test sequence
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_type       = REQ_NONE;
        value          = '0;
        position       = '0;
        res_ready      = 1'b0;
        shadow_len     = 0;
        mismatch_count = 0;
        sink_hold_left = 0;
        src_idle_pct   = 32;
        sink_stall_pct = 71;
        for (int k = 0; k < CAPACITY; k++)
            shadow_list[k] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_result_backpressure();

        src_idle_pct   = 32;
        sink_stall_pct = 71;
        test_random_traffic(490);
        src_idle_pct   = 71;
        sink_stall_pct = 32;
        test_random_traffic(490);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(490);

        // Let any stray result show up before the verdict
        wait_results_done();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/slt_pkg.sv
design/slt_cell.sv
design/sorted_list_table_unit.sv
test/tb_sorted_list_table_unit.sv
